// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CKC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define CKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ckc_pkg.sv =====
// Shared types, constants and helpers for the colour-key sprite crop block
package ckc_pkg;

  localparam int unsigned PIX_W          = 32;
  localparam int unsigned SIZE_W         = 7;
  localparam int unsigned MAX_TILE_DEF   = 64;
  localparam int unsigned EMPTY_SIZE_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic [SIZE_W-1:0] TILE_SIZE_RST = SIZE_W'(16);
  localparam logic [PIX_W-1:0]  OPAQUE_MASK   = 32'hFF00_0000;
  localparam logic [PIX_W-1:0]  KEYED_PIXEL   = 32'h0000_0000;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PIX_W-1:0]  pixel;
  } cmd_t;

  // side length clamped to [2, max_tile]; 9 bits cover max_tile up to 256
  function automatic logic [8:0] clamp_side(logic [SIZE_W-1:0] t, int unsigned max_tile);
    logic [8:0] v;
    v = 9'(t);
    if (v < 9'd2) begin
      v = 9'd2;
    end else if (v > 9'(max_tile)) begin
      v = 9'(max_tile);
    end
    return v;
  endfunction

endpackage

// ===== sv/ckc_in_if.sv =====
// Input channel: load or fetch transactions
interface ckc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [ckc_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

// ===== sv/ckc_out_if.sv =====
// Result channel: cropped pixels with sprite geometry and flags
interface ckc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ckc_pkg::PIX_W-1:0]   pixel_out;
  logic [ckc_pkg::SIZE_W-1:0]  sprite_width;
  logic [ckc_pkg::SIZE_W-1:0]  sprite_height;
  logic                        empty_tile;
  logic                        last_pixel;
  logic                        nothing_pending;

  modport source (output valid, output pixel_out, output sprite_width, output sprite_height,
                  output empty_tile, output last_pixel, output nothing_pending,
                  input ready);
  modport sink   (input valid, input pixel_out, input sprite_width, input sprite_height,
                  input empty_tile, input last_pixel, input nothing_pending,
                  output ready);
endinterface

// ===== sv/ckc_front.sv =====
// Front end: accepts input transactions and classifies them into queue commands
module ckc_front (
  ckc_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output ckc_pkg::cmd_t push_cmd
);
  import ckc_pkg::*;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_cmd.op    = in_ch.mode ? OP_FETCH : OP_LOAD;
    push_cmd.pixel = in_ch.pixel_in;
  end
endmodule

// ===== sv/ckc_queue.sv =====
// Short command queue between the front end and the back end
module ckc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ckc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          head_valid,
  output ckc_pkg::cmd_t head_cmd,
  output logic          full
);
  import ckc_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign head_valid = (count_r != '0);
  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end
endmodule

// ===== sv/ckc_back.sv =====
// Back end: tile store, bounding-box tracking, crop emission and output register
module ckc_back #(
  parameter int unsigned MAX_TILE   = ckc_pkg::MAX_TILE_DEF,
  parameter int unsigned EMPTY_SIZE = ckc_pkg::EMPTY_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ckc_pkg::SIZE_W-1:0]  cfg_wdata,
  input  logic                        head_valid,
  input  ckc_pkg::cmd_t               head_cmd,
  output logic                        pop,
  ckc_out_if.source                   out_ch
);
  import ckc_pkg::*;

  localparam int unsigned SW    = $clog2(MAX_TILE + 1);
  localparam int unsigned DEPTH = MAX_TILE * MAX_TILE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = $clog2(EMPTY_SIZE + 1);
  localparam int unsigned CW    = (SW > EW) ? SW : EW;
  localparam logic [SW-1:0] SIDE_RST = SW'(clamp_side(TILE_SIZE_RST, MAX_TILE));

  typedef struct packed {
    logic              nothing_pending;
    logic              empty_tile;
    logic              last_pixel;
    logic              use_ram;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [PIX_W-1:0]  bg;
  } meta_t;

  // configuration and load-side state
  logic [SIZE_W-1:0] tile_size_r, tile_size_nxt;
  logic [PIX_W-1:0]  bg_r, bg_nxt;
  logic [SW-1:0]     min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic [SW-1:0]     min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  logic [SW-1:0]     lx_r, lx_nxt, ly_r, ly_nxt;
  logic [AW-1:0]     ld_addr_r, ld_addr_nxt;

  // emission state
  logic              pending_r, pending_nxt;
  logic [CW-1:0]     ex_r, ex_nxt, ey_r, ey_nxt;

  // read stage and output register
  logic              s1_valid_r, s1_valid_nxt;
  meta_t             s1_r, s1_nxt;
  logic [PIX_W-1:0]  ram_q;
  logic              out_valid_r, out_valid_nxt;
  meta_t             out_meta_r;
  logic [PIX_W-1:0]  out_pix_r, out_pix_nxt;

  logic [PIX_W-1:0]  mem [DEPTH];

  logic              s1_adv, s1_free, do_load, do_fetch, mem_re;
  logic [SW-1:0]     side, new_side;
  logic              first_px, last_col, last_row, differs;
  logic              emit_empty, emit_last;
  logic [CW-1:0]     w_cnt, h_cnt;
  logic [SW-1:0]     row, col;
  logic [2*SW-1:0]   prod;
  logic [AW-1:0]     rd_addr;

  assign side     = SW'(clamp_side(tile_size_r, MAX_TILE));
  assign new_side = SW'(clamp_side(cfg_wdata, MAX_TILE));

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign s1_free  = !s1_valid_r || s1_adv;
  assign pop      = head_valid && ((head_cmd.op == OP_LOAD) || s1_free);
  assign do_load  = pop && (head_cmd.op == OP_LOAD);
  assign do_fetch = pop && (head_cmd.op == OP_FETCH);

  // load-side classification
  assign first_px = (lx_r == '0) && (ly_r == '0);
  assign last_col = (lx_r == side - SW'(1));
  assign last_row = (ly_r == side - SW'(1));
  assign differs  = (head_cmd.pixel != bg_r);

  // crop geometry; an all-background tile uses the fixed empty size
  assign emit_empty = (min_x_r > max_x_r) || (min_y_r > max_y_r);
  assign w_cnt = emit_empty ? CW'(EMPTY_SIZE) : CW'(max_x_r - min_x_r + SW'(1));
  assign h_cnt = emit_empty ? CW'(EMPTY_SIZE) : CW'(max_y_r - min_y_r + SW'(1));
  assign emit_last = (ex_r == w_cnt - CW'(1)) && (ey_r == h_cnt - CW'(1));

  assign row     = SW'(CW'(min_y_r) + ey_r);
  assign col     = SW'(CW'(min_x_r) + ex_r);
  assign prod    = row * side;
  assign rd_addr = AW'(prod + (2*SW)'(col));
  assign mem_re  = do_fetch && pending_r && !emit_empty;

  always_comb begin
    tile_size_nxt = tile_size_r;
    bg_nxt        = bg_r;
    min_x_nxt     = min_x_r;
    max_x_nxt     = max_x_r;
    min_y_nxt     = min_y_r;
    max_y_nxt     = max_y_r;
    lx_nxt        = lx_r;
    ly_nxt        = ly_r;
    ld_addr_nxt   = ld_addr_r;
    pending_nxt   = pending_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;

    if (cfg_we) begin
      tile_size_nxt = cfg_wdata;
      min_x_nxt     = new_side;
      min_y_nxt     = new_side;
      max_x_nxt     = '0;
      max_y_nxt     = '0;
      lx_nxt        = '0;
      ly_nxt        = '0;
      ld_addr_nxt   = '0;
      pending_nxt   = 1'b0;
      ex_nxt        = '0;
      ey_nxt        = '0;
    end else if (do_load) begin
      if (first_px) begin
        // new tile: first pixel sets the key and cancels any pending output
        bg_nxt      = head_cmd.pixel;
        min_x_nxt   = side;
        min_y_nxt   = side;
        max_x_nxt   = '0;
        max_y_nxt   = '0;
        pending_nxt = 1'b0;
        ex_nxt      = '0;
        ey_nxt      = '0;
      end else if (differs) begin
        if (lx_r < min_x_r) min_x_nxt = lx_r;
        if (lx_r > max_x_r) max_x_nxt = lx_r;
        if (ly_r < min_y_r) min_y_nxt = ly_r;
        if (ly_r > max_y_r) max_y_nxt = ly_r;
      end
      if (last_col) begin
        lx_nxt = '0;
        if (last_row) begin
          ly_nxt      = '0;
          ld_addr_nxt = '0;
          pending_nxt = 1'b1;
          ex_nxt      = '0;
          ey_nxt      = '0;
        end else begin
          ly_nxt      = ly_r + SW'(1);
          ld_addr_nxt = ld_addr_r + AW'(1);
        end
      end else begin
        lx_nxt      = lx_r + SW'(1);
        ld_addr_nxt = ld_addr_r + AW'(1);
      end
    end else if (do_fetch && pending_r) begin
      if (emit_last) begin
        pending_nxt = 1'b0;
        ex_nxt      = '0;
        ey_nxt      = '0;
      end else if (ex_r == w_cnt - CW'(1)) begin
        ex_nxt = '0;
        ey_nxt = ey_r + CW'(1);
      end else begin
        ex_nxt = ex_r + CW'(1);
      end
    end
  end

  // read stage and output register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (do_fetch) begin
      s1_valid_nxt           = 1'b1;
      s1_nxt.nothing_pending = !pending_r;
      s1_nxt.empty_tile      = pending_r && emit_empty;
      s1_nxt.last_pixel      = pending_r && emit_last;
      s1_nxt.use_ram         = pending_r && !emit_empty;
      s1_nxt.width           = pending_r ? SIZE_W'(w_cnt) : '0;
      s1_nxt.height          = pending_r ? SIZE_W'(h_cnt) : '0;
      s1_nxt.bg              = bg_r;
    end

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end

    // read pixels matching a non-zero key turn zero, the rest are forced opaque
    if (!s1_r.use_ram) begin
      out_pix_nxt = '0;
    end else if ((s1_r.bg != '0) && (ram_q == s1_r.bg)) begin
      out_pix_nxt = KEYED_PIXEL;
    end else begin
      out_pix_nxt = ram_q | OPAQUE_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r <= TILE_SIZE_RST;
      bg_r        <= '0;
      min_x_r     <= SIDE_RST;
      min_y_r     <= SIDE_RST;
      max_x_r     <= '0;
      max_y_r     <= '0;
      lx_r        <= '0;
      ly_r        <= '0;
      ld_addr_r   <= '0;
      pending_r   <= 1'b0;
      ex_r        <= '0;
      ey_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tile_size_r <= tile_size_nxt;
      bg_r        <= bg_nxt;
      min_x_r     <= min_x_nxt;
      min_y_r     <= min_y_nxt;
      max_x_r     <= max_x_nxt;
      max_y_r     <= max_y_nxt;
      lx_r        <= lx_nxt;
      ly_r        <= ly_nxt;
      ld_addr_r   <= ld_addr_nxt;
      pending_r   <= pending_nxt;
      ex_r        <= ex_nxt;
      ey_r        <= ey_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (s1_adv) begin
      out_meta_r <= s1_r;
      out_pix_r  <= out_pix_nxt;
    end
  end

  // tile store: one write port for loads, one registered read port for fetches
  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[ld_addr_r] <= head_cmd.pixel;
    end
    if (mem_re) begin
      ram_q <= mem[rd_addr];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pixel_out       = out_pix_r;
  assign out_ch.sprite_width    = out_meta_r.width;
  assign out_ch.sprite_height   = out_meta_r.height;
  assign out_ch.empty_tile      = out_meta_r.empty_tile;
  assign out_ch.last_pixel      = out_meta_r.last_pixel;
  assign out_ch.nothing_pending = out_meta_r.nothing_pending;
endmodule

// ===== sv/color_key_sprite_crop_core.sv =====
// Throughput: one transaction per cycle, loads and fetches alike, if the queue has
// room and the result channel is not stalled; the tile store has one write port
// and one registered read port, so each does one pixel a cycle. A fetch result goes
// through the queue, the store read stage and the output register; a load goes
// through the queue to the tile store. Reset: synchronous, active low; control
// state clears at once, no clearing pass, tile store contents are left as they were.
module color_key_sprite_crop_core #(
  parameter int unsigned MAX_TILE   = ckc_pkg::MAX_TILE_DEF,
  parameter int unsigned EMPTY_SIZE = ckc_pkg::EMPTY_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ckc_pkg::SIZE_W-1:0]  cfg_wdata,
  ckc_in_if.sink                      in_ch,
  ckc_out_if.source                   out_ch
);
  import ckc_pkg::*;

  logic  push, pop, q_full, head_valid;
  cmd_t  push_cmd, head_cmd;

  ckc_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ckc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (q_full)
  );

  ckc_back #(
    .MAX_TILE   (MAX_TILE),
    .EMPTY_SIZE (EMPTY_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );
endmodule

// ===== sv/ckc_checker.sv =====
// Port-level checks on the result channel, bound to the top level
`include "assert_macros.svh"

module ckc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ckc_pkg::PIX_W-1:0]   pixel_out,
  input logic [ckc_pkg::SIZE_W-1:0]  sprite_width,
  input logic [ckc_pkg::SIZE_W-1:0]  sprite_height,
  input logic                        empty_tile,
  input logic                        last_pixel,
  input logic                        nothing_pending
);
  import ckc_pkg::*;

  `CKC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CKC_ASSERT_NOW(a_idle_fields_zero, clk, rst_n, out_valid && nothing_pending, (pixel_out == '0) && (sprite_width == '0) && (sprite_height == '0) && !empty_tile && !last_pixel)
  `CKC_ASSERT_NOW(a_empty_is_zero, clk, rst_n, out_valid && empty_tile, (pixel_out == '0) && !nothing_pending)
  `CKC_ASSERT_NOW(a_opaque, clk, rst_n, out_valid && (pixel_out != '0), pixel_out[31:24] == 8'hFF)
  `CKC_ASSERT_NOW(a_reset_quiet, clk, rst_n, !$past(rst_n), !out_valid)
endmodule

bind color_key_sprite_crop_core ckc_checker u_ckc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .pixel_out       (out_ch.pixel_out),
  .sprite_width    (out_ch.sprite_width),
  .sprite_height   (out_ch.sprite_height),
  .empty_tile      (out_ch.empty_tile),
  .last_pixel      (out_ch.last_pixel),
  .nothing_pending (out_ch.nothing_pending)
);
